// File: design/glop_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the GPIO line ownership port.
// Depends on nothing; used by the top level and the testbench.
package glop_pkg;

   localparam int LINE_COUNT   = 16;
   localparam int HANDLE_COUNT = 8;
   localparam int LINE_W       = 16;
   localparam int MODE_W       = 32;
   localparam int HANDLE_W     = 3;
   localparam int CSR_IDX_W    = 2;

   localparam logic [31:0] LINE_MASK32 = (LINE_COUNT >= 32) ? 32'hFFFF_FFFF
                                         : ((32'h1 << LINE_COUNT) - 32'h1);
   localparam logic [LINE_W-1:0] LINE_MASK = LINE_MASK32[LINE_W-1:0];

   localparam logic [MODE_W-1:0] OUTPUT_FIELDS = 32'h5555_5555;

   // Request operation codes.
   localparam logic [3:0] OP_CLAIM      = 4'd0;
   localparam logic [3:0] OP_RELEASE    = 4'd1;
   localparam logic [3:0] OP_ASSERT     = 4'd2;
   localparam logic [3:0] OP_DEASSERT   = 4'd3;
   localparam logic [3:0] OP_READ       = 4'd4;
   localparam logic [3:0] OP_WRITE      = 4'd5;
   localparam logic [3:0] OP_SET_INPUT  = 4'd6;
   localparam logic [3:0] OP_SET_OUTPUT = 4'd7;
   localparam logic [3:0] OP_OPEN       = 4'd8;
   localparam logic [3:0] OP_CLOSE      = 4'd9;
   localparam logic [3:0] OP_DUPLICATE  = 4'd10;

   // Result status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BUSY        = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CLAIMABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MODE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_OUT  = 2'd3;

   // Request fields held while the owned mask is read from memory.
   typedef struct packed {
      logic [3:0]          op;
      logic [HANDLE_W-1:0] handle;
      logic [HANDLE_W-1:0] target;
      logic [LINE_W-1:0]   lines;
      logic [LINE_W-1:0]   values;
      logic [LINE_W-1:0]   pins;
      logic                unsupported;
      logic                own_valid;
   } req_type;

   // Expands a line mask into a mask of the two-bit mode fields.
   function automatic logic [MODE_W-1:0] spread_fields(input logic [LINE_W-1:0] lines);
      logic [MODE_W-1:0] fields;
      fields = '0;
      for (int i = 0; i < LINE_W; i++) begin
         fields[2*i +: 2] = {2{lines[i]}};
      end
      return fields;
   endfunction

endpackage

// File: design/glop_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module glop_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/gpio_line_ownership_port_top.sv
`timescale 1ns / 1ps
// GPIO port with per-handle line ownership; owned masks live in glop_ram.
// Depends on glop_pkg and glop_ram.
// An accepted request has its owned mask read from memory and enters S_EXEC; the modify
// and write-back follow there, and the result retires once the result register is free.
// Requests stall while one is in S_EXEC. A waiting result does not block the next read.
// Reset: synchronous, active high. Masks, latch and mode word clear at once; each
// owned-mask entry carries a valid bit, so no clearing pass is needed.
module gpio_line_ownership_port_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_mode,
   input  logic [glop_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [glop_pkg::HANDLE_W-1:0]     req_target_handle,
   input  logic [glop_pkg::LINE_W-1:0]       req_lines,
   input  logic [glop_pkg::LINE_W-1:0]       req_values,
   input  logic [glop_pkg::LINE_W-1:0]       req_pin_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [glop_pkg::LINE_W-1:0]       rsp_read_data,
   output logic [glop_pkg::LINE_W-1:0]       rsp_output_levels,
   output logic [glop_pkg::MODE_W-1:0]       rsp_pin_modes,
   input  logic                              csr_write,
   input  logic [glop_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [glop_pkg::MODE_W-1:0]       csr_data
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                          state_ff, state_in;
   glop_pkg::req_type             req_ff, req_in;
   logic [glop_pkg::HANDLE_COUNT-1:0] valid_ff, valid_in;
   logic [glop_pkg::LINE_W-1:0]   claimable_ff, claimable_in;
   logic [glop_pkg::LINE_W-1:0]   dynamic_ff, dynamic_in;
   logic [glop_pkg::LINE_W-1:0]   taken_ff, taken_in;
   logic [glop_pkg::LINE_W-1:0]   latch_ff, latch_in;
   logic [glop_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    status_ff, status_in;
   logic [glop_pkg::LINE_W-1:0]   rdata_ff, rdata_in;

   logic                          accept;
   logic                          commit;
   logic [glop_pkg::LINE_W-1:0]   ram_rdata;
   logic [glop_pkg::LINE_W-1:0]   own;
   logic [glop_pkg::LINE_W-1:0]   sel;
   logic [glop_pkg::MODE_W-1:0]   fields;
   logic                          wr_en;
   logic [glop_pkg::HANDLE_W-1:0] wr_addr;
   logic [glop_pkg::LINE_W-1:0]   wr_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   // The result register must be free, or emptied in this cycle, before a request retires.
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   glop_ram #(
      .WIDTH(glop_pkg::LINE_W),
      .DEPTH(glop_pkg::HANDLE_COUNT)
   ) u_owned_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(req_handle),
      .rd_data(ram_rdata)
   );

   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.op          = req_mode;
         req_in.handle      = req_handle;
         req_in.target      = req_target_handle;
         req_in.lines       = req_lines & glop_pkg::LINE_MASK;
         req_in.values      = req_values & glop_pkg::LINE_MASK;
         req_in.pins        = req_pin_levels & glop_pkg::LINE_MASK;
         req_in.unsupported = (req_mode > glop_pkg::OP_DUPLICATE)
                              || (int'(req_handle) >= glop_pkg::HANDLE_COUNT)
                              || ((req_mode == glop_pkg::OP_DUPLICATE)
                                  && (int'(req_target_handle) >= glop_pkg::HANDLE_COUNT));
         req_in.own_valid   = valid_ff[req_handle];
      end
   end

   // An entry never written since reset reads as an empty mask.
   assign own    = req_ff.own_valid ? ram_rdata : '0;
   assign sel    = req_ff.lines & own;
   assign fields = glop_pkg::spread_fields(sel & dynamic_ff);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      claimable_in = claimable_ff;
      dynamic_in   = dynamic_ff;
      taken_in     = taken_ff;
      latch_in     = latch_ff;
      mode_in      = mode_ff;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = req_ff.handle;
      wr_data      = '0;

      if (accept) begin
         state_in = S_EXEC;
      end

      if (commit) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = glop_pkg::ST_OK;
         rdata_in     = '0;
         if (req_ff.unsupported) begin
            status_in = glop_pkg::ST_UNSUPPORTED;
         end else begin
            case (req_ff.op)
               glop_pkg::OP_CLAIM: begin
                  if ((req_ff.lines & ~(claimable_ff & ~taken_ff)) != '0) begin
                     status_in = glop_pkg::ST_BUSY;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = own | req_ff.lines;
                     taken_in = taken_ff | req_ff.lines;
                  end
               end
               glop_pkg::OP_RELEASE: begin
                  wr_en    = 1'b1;
                  wr_data  = own & ~sel;
                  taken_in = taken_ff & ~sel;
               end
               glop_pkg::OP_ASSERT:   latch_in = latch_ff | sel;
               glop_pkg::OP_DEASSERT: latch_in = latch_ff & ~sel;
               glop_pkg::OP_READ:     rdata_in = req_ff.pins & own;
               glop_pkg::OP_WRITE:    latch_in = (latch_ff & ~sel) | (req_ff.values & own);
               glop_pkg::OP_SET_INPUT:  mode_in = mode_ff & ~fields;
               glop_pkg::OP_SET_OUTPUT: begin
                  mode_in = (mode_ff & ~fields) | (fields & glop_pkg::OUTPUT_FIELDS);
               end
               glop_pkg::OP_OPEN: begin
                  wr_en = 1'b1;
               end
               glop_pkg::OP_CLOSE: begin
                  wr_en    = 1'b1;
                  taken_in = taken_ff & ~own;
               end
               glop_pkg::OP_DUPLICATE: begin
                  // The target is cleared first, so a handle duplicating onto itself succeeds.
                  wr_en   = 1'b1;
                  wr_addr = req_ff.target;
                  if ((req_ff.target != req_ff.handle) && (own != '0)) begin
                     status_in = glop_pkg::ST_BUSY;
                  end
               end
               default: status_in = glop_pkg::ST_UNSUPPORTED;
            endcase
         end
         if (wr_en) begin
            valid_in[wr_addr] = 1'b1;
         end
      end

      if (csr_write) begin
         case (csr_index)
            glop_pkg::CSR_CLAIMABLE: claimable_in = csr_data[glop_pkg::LINE_W-1:0];
            glop_pkg::CSR_DYNAMIC:   dynamic_in   = csr_data[glop_pkg::LINE_W-1:0];
            glop_pkg::CSR_INIT_MODE: mode_in      = csr_data;
            glop_pkg::CSR_INIT_OUT: begin
               latch_in = csr_data[glop_pkg::LINE_W-1:0] & glop_pkg::LINE_MASK;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         claimable_ff <= '0;
         dynamic_ff   <= '0;
         taken_ff     <= '0;
         latch_ff     <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         claimable_ff <= claimable_in;
         dynamic_ff   <= dynamic_in;
         taken_ff     <= taken_in;
         latch_ff     <= latch_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_data     = rdata_ff;
   assign rsp_output_levels = latch_ff;
   assign rsp_pin_modes     = mode_ff;

endmodule

// File: verif/tb_gpio_line_ownership_port_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gpio_line_ownership_port_top: claims, ownership, latch and mode
// updates are predicted per accepted request and compared with every result in order.
// Depends on glop_pkg and the design under test.
module tb_gpio_line_ownership_port_top;

   typedef struct packed {
      logic [3:0]                    mode;
      logic [glop_pkg::HANDLE_W-1:0] handle;
      logic [glop_pkg::HANDLE_W-1:0] target;
      logic [glop_pkg::LINE_W-1:0]   lines;
      logic [glop_pkg::LINE_W-1:0]   values;
      logic [glop_pkg::LINE_W-1:0]   pins;
   } port_request_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic [glop_pkg::LINE_W-1:0] read_data;
      logic [glop_pkg::LINE_W-1:0] out_levels;
      logic [glop_pkg::MODE_W-1:0] pin_modes;
   } port_result_type;

   typedef struct packed {
      logic [glop_pkg::HANDLE_COUNT-1:0][glop_pkg::LINE_W-1:0] owned;
      logic [glop_pkg::LINE_W-1:0]                             taken;
      logic [glop_pkg::LINE_W-1:0]                             latch;
      logic [glop_pkg::MODE_W-1:0]                             modes;
      logic [glop_pkg::LINE_W-1:0]                             claimable_lines;
      logic [glop_pkg::LINE_W-1:0]                             dyn_lines;
   } port_state_type;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 40;

   logic                           clock;
   logic                           reset             = 1'b1;
   logic                           req_valid         = 1'b0;
   logic                           req_stall;
   logic [3:0]                     req_mode          = '0;
   logic [glop_pkg::HANDLE_W-1:0]  req_handle        = '0;
   logic [glop_pkg::HANDLE_W-1:0]  req_target_handle = '0;
   logic [glop_pkg::LINE_W-1:0]    req_lines         = '0;
   logic [glop_pkg::LINE_W-1:0]    req_values        = '0;
   logic [glop_pkg::LINE_W-1:0]    req_pin_levels    = '0;
   logic                           rsp_valid;
   logic                           rsp_stall         = 1'b0;
   logic [1:0]                     rsp_status;
   logic [glop_pkg::LINE_W-1:0]    rsp_read_data;
   logic [glop_pkg::LINE_W-1:0]    rsp_output_levels;
   logic [glop_pkg::MODE_W-1:0]    rsp_pin_modes;
   logic                           csr_write         = 1'b0;
   logic [glop_pkg::CSR_IDX_W-1:0] csr_index         = '0;
   logic [glop_pkg::MODE_W-1:0]    csr_data          = '0;

   // live_port follows accepted requests; planned_port follows the generated stream,
   // which is applied in the same order, so both agree once the queue drains.
   port_state_type   live_port    = '0;
   port_state_type   planned_port = '0;
   port_request_type pending_requests[$];
   port_result_type  expected_results[$];
   port_result_type  accepted_result;
   port_result_type  want;

   int  fail_count     = 0;
   int  accepted_count = 0;
   int  idle_cycles    = 0;
   int  burst_left     = 1;
   int  gap_left       = 0;
   int  stall_level    = 0;
   int  stall_period   = 0;
   int  stall_phase    = 0;
   bit  drain_hold     = 1'b0;
   bit  drained_once   = 1'b0;

   gpio_line_ownership_port_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_handle        (req_handle),
      .req_target_handle (req_target_handle),
      .req_lines         (req_lines),
      .req_values        (req_values),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_output_levels (rsp_output_levels),
      .rsp_pin_modes     (rsp_pin_modes),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [glop_pkg::MODE_W-1:0] line_fields(
         input logic [glop_pkg::LINE_W-1:0] lines);
      logic [glop_pkg::MODE_W-1:0] f;
      f = '0;
      for (int i = 0; i < glop_pkg::LINE_W; i++) begin
         if (lines[i]) f[2*i +: 2] = 2'b11;
      end
      return f;
   endfunction

   function automatic logic [glop_pkg::LINE_W-1:0] rand_lines();
      logic [31:0] r;
      r = $urandom;
      return r[glop_pkg::LINE_W-1:0];
   endfunction

   function automatic port_state_type step_port(input port_state_type s,
                                                input port_request_type r,
                                                output port_result_type res);
      port_state_type              n;
      logic [glop_pkg::LINE_W-1:0] own;
      logic [glop_pkg::LINE_W-1:0] sel;
      logic [glop_pkg::MODE_W-1:0] fields;
      n = s;
      own = s.owned[r.handle];
      sel = r.lines & own;
      res.status = glop_pkg::ST_OK;
      res.read_data = '0;
      if (r.mode > glop_pkg::OP_DUPLICATE) begin
         res.status = glop_pkg::ST_UNSUPPORTED;
      end else begin
         case (r.mode)
            glop_pkg::OP_CLAIM: begin
               if ((r.lines & ~(s.claimable_lines & ~s.taken)) != '0) begin
                  res.status = glop_pkg::ST_BUSY;
               end else begin
                  n.owned[r.handle] = own | r.lines;
                  n.taken = s.taken | r.lines;
               end
            end
            glop_pkg::OP_RELEASE: begin
               n.owned[r.handle] = own & ~sel;
               n.taken = s.taken & ~sel;
            end
            glop_pkg::OP_ASSERT:   n.latch = s.latch | sel;
            glop_pkg::OP_DEASSERT: n.latch = s.latch & ~sel;
            glop_pkg::OP_READ:     res.read_data = r.pins & own;
            // Ones in the values of every owned line land, not only on requested lines; zeros land only there.
            glop_pkg::OP_WRITE:    n.latch = (s.latch & ~sel) | (r.values & own);
            glop_pkg::OP_SET_INPUT: begin
               fields = line_fields(sel & s.dyn_lines);
               n.modes = s.modes & ~fields;
            end
            glop_pkg::OP_SET_OUTPUT: begin
               fields = line_fields(sel & s.dyn_lines);
               n.modes = (s.modes & ~fields) | (fields & glop_pkg::OUTPUT_FIELDS);
            end
            glop_pkg::OP_OPEN: n.owned[r.handle] = '0;
            glop_pkg::OP_CLOSE: begin
               n.taken = s.taken & ~own;
               n.owned[r.handle] = '0;
            end
            default: begin
               // Duplicate clears the target first, so a handle duplicating onto
               // itself ends up owning nothing and succeeds.
               n.owned[r.target] = '0;
               res.status = (n.owned[r.handle] != '0) ? glop_pkg::ST_BUSY : glop_pkg::ST_OK;
            end
         endcase
      end
      n.latch = n.latch & glop_pkg::LINE_MASK;
      res.out_levels = n.latch;
      res.pin_modes = n.modes;
      return n;
   endfunction

   function automatic port_state_type apply_csr(input port_state_type s,
                                                input logic [glop_pkg::CSR_IDX_W-1:0] idx,
                                                input logic [glop_pkg::MODE_W-1:0] d);
      port_state_type n;
      n = s;
      case (idx)
         glop_pkg::CSR_CLAIMABLE: n.claimable_lines = d[glop_pkg::LINE_W-1:0];
         glop_pkg::CSR_DYNAMIC:   n.dyn_lines = d[glop_pkg::LINE_W-1:0];
         glop_pkg::CSR_INIT_MODE: n.modes = d;
         default:                 n.latch = d[glop_pkg::LINE_W-1:0] & glop_pkg::LINE_MASK;
      endcase
      return n;
   endfunction

   task automatic push_request(input logic [3:0] mode, input int handle, input int target,
                               input logic [glop_pkg::LINE_W-1:0] lines,
                               input logic [glop_pkg::LINE_W-1:0] values,
                               input logic [glop_pkg::LINE_W-1:0] pins);
      port_request_type r;
      port_result_type  unused;
      r.mode = mode;
      r.handle = handle[glop_pkg::HANDLE_W-1:0];
      r.target = target[glop_pkg::HANDLE_W-1:0];
      r.lines = lines;
      r.values = values;
      r.pins = pins;
      planned_port = step_port(planned_port, r, unused);
      pending_requests.push_back(r);
   endtask

   task automatic write_csr(input logic [glop_pkg::CSR_IDX_W-1:0] idx,
                            input logic [glop_pkg::MODE_W-1:0] d);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      live_port    = apply_csr(live_port, idx, d);
      planned_port = apply_csr(planned_port, idx, d);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [glop_pkg::LINE_W-1:0] claimable,
                            input logic [glop_pkg::LINE_W-1:0] dyn,
                            input logic [glop_pkg::MODE_W-1:0] init_mode,
                            input logic [glop_pkg::LINE_W-1:0] init_out);
      write_csr(glop_pkg::CSR_CLAIMABLE, {16'h0, claimable});
      write_csr(glop_pkg::CSR_DYNAMIC, {16'h0, dyn});
      write_csr(glop_pkg::CSR_INIT_MODE, init_mode);
      write_csr(glop_pkg::CSR_INIT_OUT, {16'h0, init_out});
   endtask

   // Prefers a handle that owns lines (or owns none), so that most requests do real work
   // and opens and duplicates seldom strand taken lines.
   function automatic int pick_handle(input bit want_owner);
      int h;
      h = 0;
      for (int k = 0; k < 8; k++) begin
         h = $urandom_range(0, glop_pkg::HANDLE_COUNT - 1);
         if ((planned_port.owned[h[glop_pkg::HANDLE_W-1:0]] != '0) == want_owner) return h;
      end
      return h;
   endfunction

   task automatic queue_random_requests(input int count);
      int                          h;
      int                          t;
      int                          pick;
      logic [3:0]                  mode;
      logic [glop_pkg::LINE_W-1:0] lines;
      logic [glop_pkg::LINE_W-1:0] free_lines;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         h = pick_handle($urandom_range(0, 3) != 0);
         t = $urandom_range(0, glop_pkg::HANDLE_COUNT - 1);
         lines = planned_port.owned[h[glop_pkg::HANDLE_W-1:0]] & rand_lines();
         if ($urandom_range(0, 4) == 0) lines = lines | (rand_lines() & rand_lines());
         if ($urandom_range(0, 5) == 0) lines = rand_lines();
         if (pick < 4) begin
            mode = 4'($urandom_range(11, 15));
         end else if (pick < 28) begin
            mode = glop_pkg::OP_CLAIM;
            h = pick_handle($urandom_range(0, 2) == 0);
            free_lines = planned_port.claimable_lines & ~planned_port.taken;
            lines = free_lines & rand_lines() & rand_lines();
            if ($urandom_range(0, 4) == 0) lines = rand_lines() & rand_lines();
         end else if (pick < 37) begin
            mode = glop_pkg::OP_RELEASE;
         end else if (pick < 45) begin
            mode = glop_pkg::OP_ASSERT;
         end else if (pick < 51) begin
            mode = glop_pkg::OP_DEASSERT;
         end else if (pick < 59) begin
            mode = glop_pkg::OP_READ;
         end else if (pick < 67) begin
            mode = glop_pkg::OP_WRITE;
         end else if (pick < 75) begin
            mode = glop_pkg::OP_SET_INPUT;
         end else if (pick < 83) begin
            mode = glop_pkg::OP_SET_OUTPUT;
         end else if (pick < 88) begin
            mode = glop_pkg::OP_OPEN;
            h = pick_handle($urandom_range(0, 7) == 0);
         end else if (pick < 93) begin
            mode = glop_pkg::OP_CLOSE;
         end else begin
            mode = glop_pkg::OP_DUPLICATE;
            h = $urandom_range(0, glop_pkg::HANDLE_COUNT - 1);
            t = pick_handle($urandom_range(0, 7) == 0);
         end
         push_request(mode, h, t, lines, rand_lines(), rand_lines());
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what,
                  exp_val, act_val);
      end
   endtask

   // Request driver: bursts of random length, random gaps, and an occasional hold-off
   // until every outstanding result has come back.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            live_port = step_port(live_port, pending_requests[0], accepted_result);
            expected_results.push_back(accepted_result);
            void'(pending_requests.pop_front());
            accepted_count++;
         end
         if (!(req_valid && req_stall)) begin
            if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
            if (gap_left > 0 || drain_hold || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid         <= 1'b1;
               req_mode          <= pending_requests[0].mode;
               req_handle        <= pending_requests[0].handle;
               req_target_handle <= pending_requests[0].target;
               req_lines         <= pending_requests[0].lines;
               req_values        <= pending_requests[0].values;
               req_pin_levels    <= pending_requests[0].pins;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                  if ((!drained_once && accepted_count >= 40) ||
                      $urandom_range(0, 19) == 0) begin
                     drain_hold = 1'b1;
                     drained_once = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Result stall: a new pattern is drawn whenever its random period runs out, including
   // stretches with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_period == 0) begin
            stall_level = $urandom_range(0, 3);
            stall_period = $urandom_range(20, 120);
         end
         stall_period--;
         stall_phase = (stall_phase + 1) % 5;
         case (stall_level)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= (stall_phase < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT) begin
               $display("%0t: result with no request outstanding: expected none, actual %0d",
                        $time, rsp_status);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", 32'(want.read_data), 32'(rsp_read_data));
            if (rsp_output_levels !== want.out_levels)
               report_mismatch("output_levels", 32'(want.out_levels),
                               32'(rsp_output_levels));
            if (rsp_pin_modes !== want.pin_modes)
               report_mismatch("pin_modes", want.pin_modes, rsp_pin_modes);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_requests.size() == 0 && expected_results.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(16'hFFFF, 16'hFFFF, 32'h0, 16'h0);
      push_request(glop_pkg::OP_READ,       0, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
      push_request(glop_pkg::OP_CLAIM,      0, 0, 16'h000F, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      1, 0, 16'h8001, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      1, 0, 16'h8000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      2, 0, 16'h0000, 16'hFFFF, 16'hFFFF);
      push_request(glop_pkg::OP_ASSERT,     0, 0, 16'hFFFF, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_DEASSERT,   0, 0, 16'h0003, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_WRITE,      0, 0, 16'h0001, 16'hFFFF, 16'h0000);
      push_request(glop_pkg::OP_WRITE,      1, 0, 16'h8000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_READ,       1, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
      push_request(glop_pkg::OP_SET_OUTPUT, 0, 0, 16'hFFFF, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_SET_OUTPUT, 1, 0, 16'hFFFF, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_SET_INPUT,  0, 0, 16'h0005, 16'h0000, 16'h0000);
      push_request(4'd11,                   0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_request(4'd15,                   7, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_request(glop_pkg::OP_DUPLICATE,  0, 3, 16'h0000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_DUPLICATE,  3, 3, 16'h0000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_DUPLICATE,  1, 1, 16'h0000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      2, 0, 16'h8000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLOSE,      0, 0, 16'h0000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_OPEN,       2, 0, 16'h0000, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_RELEASE,    1, 0, 16'hFFFF, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      4, 0, 16'h0001, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_RELEASE,    4, 0, 16'h0001, 16'h0000, 16'h0000);
      push_request(glop_pkg::OP_CLAIM,      7, 0, 16'h7FFE, 16'h0000, 16'h0000);
      queue_random_requests(200);
      wait_drained();

      // No line is dynamic and every mode field starts at 11.
      configure(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
      queue_random_requests(150);
      wait_drained();

      // Nothing is claimable, so only lines owned already can be worked.
      configure(16'h0000, 16'hFFFF, $urandom, rand_lines());
      queue_random_requests(100);
      wait_drained();

      configure(rand_lines(), rand_lines(), $urandom, rand_lines());
      queue_random_requests(150);
      wait_drained();

      configure(16'hFFFF, 16'hFFFF, 32'hA5A5_5A5A, 16'h0000);
      queue_random_requests(150);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/glop_pkg.sv
design/glop_ram.sv
design/gpio_line_ownership_port_top.sv
verif/tb_gpio_line_ownership_port_top.sv
